/* sv/lru_index_linked_list_macros.svh */
// Assertion helpers for lru_index_linked_list.sv.
`ifndef LRU_INDEX_LINKED_LIST_MACROS_SVH
`define LRU_INDEX_LINKED_LIST_MACROS_SVH

// Same-cycle implication, checked on every aclk edge outside reset.
`define LRU_ILL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lru_index_linked_list: invariant violated");

// Next-cycle implication, checked on every aclk edge outside reset.
`define LRU_ILL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lru_index_linked_list: sequence violated");

`endif

/* sv/lru_ill_pkg.sv */
`default_nettype none

package lru_ill_pkg;

    localparam int MODE_W = 3;
    localparam int NODE_W = 10;

    localparam logic [MODE_W-1:0] MODE_ADD_HEAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_TAIL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOVE_HEAD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE_TAIL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;

endpackage

`default_nettype wire

/* sv/lru_ill_ram.sv */
`default_nettype none

module lru_ill_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/lru_index_linked_list.sv */
`default_nettype none
// LRU order over a pool of NODE_COUNT slots, kept as a circular doubly linked
// list; slot 0 is the root, its next link is the head and its prev link the tail.
// Input channel (s_valid/s_ready): one word = s_mode + s_node_index, a request.
// Result channel (m_valid/m_ready): one word per request = m_applied,
//   m_list_empty, m_head_index, m_tail_index as seen after the request.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes lru_enable; always
//   ready. Write it only while no request is in flight.
// Steps from accept: refused EVAL, DONE; add head/tail EVAL, LINK_A, LINK_B,
//   DONE; remove EVAL, UNLINK, SELF, DONE; move head/tail EVAL, UNLINK,
//   LINK_A, LINK_B, DONE. The next request may be accepted in the cycle its
//   predecessor's result is loaded. The steps follow from the registered read
//   of the slot's links and one write per step on each of the two link memories.
// Reset: aresetn (synchronous, active low) sets lru_enable to 1 and starts a
//   clearing pass that writes every slot's links to itself, during which
//   s_ready stays low; config writes are taken as ever.
// Stall: the result sits in an output register; a new request is still taken
//   and worked on, and only its completion waits until m_ready frees the
//   register.

`include "lru_index_linked_list_macros.svh"

module lru_index_linked_list #(
    parameter int NODE_COUNT = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lru_ill_pkg::MODE_W-1:0]  s_mode,
    input  wire logic [lru_ill_pkg::NODE_W-1:0]  s_node_index,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_applied,
    output logic                                 m_list_empty,
    output logic      [lru_ill_pkg::NODE_W-1:0]  m_head_index,
    output logic      [lru_ill_pkg::NODE_W-1:0]  m_tail_index,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int EXT_W = (IDX_W > lru_ill_pkg::NODE_W) ? IDX_W : lru_ill_pkg::NODE_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NODE_COUNT - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_UNLINK = 3'd3;
    localparam logic [2:0] ST_LINK_A = 3'd4;
    localparam logic [2:0] ST_LINK_B = 3'd5;
    localparam logic [2:0] ST_SELF   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // control
    logic [2:0]                     state_reg, state_next;
    logic [IDX_W-1:0]               clr_cnt_reg;
    logic                           lru_enable_reg;
    logic                           m_valid_reg;
    logic [IDX_W-1:0]               head_reg, tail_reg;

    // request context
    logic [lru_ill_pkg::MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]               node_reg;
    logic                           in_range_reg;
    logic [IDX_W-1:0]               p_reg, n_reg, cap_reg;
    logic                           applied_reg;

    // result payload
    logic                           m_applied_reg, m_list_empty_reg;
    logic [lru_ill_pkg::NODE_W-1:0] m_head_index_reg, m_tail_index_reg;

    // memory ports
    logic                           prev_we, next_we;
    logic [IDX_W-1:0]               prev_waddr, next_waddr, prev_wdata, next_wdata;
    logic [IDX_W-1:0]               rd_addr, prev_rdata, next_rdata;

    logic                           in_accept, out_free, head_side, guard_ok, mode_ok;
    logic                           quiet_state;
    logic [EXT_W-1:0]               node_ext, head_ext, tail_ext;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign cfg_ready = 1'b1;

    assign node_ext  = EXT_W'(s_node_index);
    assign rd_addr   = node_ext[IDX_W-1:0];
    assign head_ext  = EXT_W'(head_reg);
    assign tail_ext  = EXT_W'(tail_reg);
    assign head_side = (mode_reg == lru_ill_pkg::MODE_ADD_HEAD) ||
                       (mode_reg == lru_ill_pkg::MODE_MOVE_HEAD);

    // States in which neither link memory is written.
    assign quiet_state = (state_reg inside {ST_IDLE, ST_EVAL, ST_DONE});

    lru_ill_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    lru_ill_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    // Guards, evaluated on the slot's links as read back in EVAL.
    always_comb begin
        case (mode_reg)
            lru_ill_pkg::MODE_ADD_HEAD: begin
                mode_ok = (next_rdata == node_reg) && (prev_rdata == node_reg);
            end
            lru_ill_pkg::MODE_ADD_TAIL: begin
                mode_ok = lru_enable_reg && (next_rdata == node_reg) &&
                          (prev_rdata == node_reg);
            end
            lru_ill_pkg::MODE_MOVE_HEAD: begin
                mode_ok = lru_enable_reg && (next_rdata != node_reg) &&
                          (prev_rdata != node_reg) && (next_rdata != prev_rdata) &&
                          (prev_rdata != '0);
            end
            lru_ill_pkg::MODE_MOVE_TAIL: begin
                mode_ok = lru_enable_reg && (next_rdata != node_reg) &&
                          (prev_rdata != node_reg) && (next_rdata != prev_rdata) &&
                          (next_rdata != '0);
            end
            lru_ill_pkg::MODE_REMOVE: begin
                mode_ok = (next_rdata != node_reg) && (prev_rdata != node_reg);
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase
        guard_ok = in_range_reg && (node_reg != '0) && mode_ok;
    end

    // Link writes, one per memory per cycle, kept in the list's write order:
    //   UNLINK  prev[n]=p, next[p]=n        (join neighbors)
    //   LINK_A  head: prev[h]=s, next[s]=h  tail: prev[root]=s, next[s]=root
    //   LINK_B  head: prev[s]=root, next[root]=s
    //           tail: prev[s]=t, next[t]=s  (t = tail before LINK_A)
    //   SELF    prev[s]=s, next[s]=s        (remove only)
    always_comb begin
        prev_we    = 1'b0;
        next_we    = 1'b0;
        prev_waddr = node_reg;
        prev_wdata = node_reg;
        next_waddr = node_reg;
        next_wdata = node_reg;
        case (state_reg)
            ST_CLEAR: begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                prev_waddr = clr_cnt_reg;
                prev_wdata = clr_cnt_reg;
                next_waddr = clr_cnt_reg;
                next_wdata = clr_cnt_reg;
            end
            ST_UNLINK: begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                prev_waddr = n_reg;
                prev_wdata = p_reg;
                next_waddr = p_reg;
                next_wdata = n_reg;
            end
            ST_LINK_A: begin
                prev_we = 1'b1;
                next_we = 1'b1;
                if (head_side) begin
                    prev_waddr = head_reg;
                    next_wdata = head_reg;
                end else begin
                    prev_waddr = '0;
                    next_wdata = '0;
                end
            end
            ST_LINK_B: begin
                prev_we = 1'b1;
                next_we = 1'b1;
                if (head_side) begin
                    prev_wdata = '0;
                    next_waddr = '0;
                end else begin
                    prev_wdata = cap_reg;
                    next_waddr = cap_reg;
                end
            end
            ST_SELF: begin
                prev_we = 1'b1;
                next_we = 1'b1;
            end
            default: begin
                prev_we = 1'b0;
                next_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!guard_ok) begin
                    state_next = ST_DONE;
                end else if ((mode_reg == lru_ill_pkg::MODE_ADD_HEAD) ||
                             (mode_reg == lru_ill_pkg::MODE_ADD_TAIL)) begin
                    state_next = ST_LINK_A;
                end else begin
                    state_next = ST_UNLINK;
                end
            end
            ST_UNLINK: begin
                state_next = (mode_reg == lru_ill_pkg::MODE_REMOVE) ? ST_SELF : ST_LINK_A;
            end
            ST_LINK_A: begin
                state_next = ST_LINK_B;
            end
            ST_LINK_B, ST_SELF: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = in_accept ? ST_EVAL : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, including the root link shadows that track every
    // write to the root entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            lru_enable_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                lru_enable_reg <= cfg_data;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (next_we && (next_waddr == '0)) begin
                head_reg <= next_wdata;
            end
            if (prev_we && (prev_waddr == '0)) begin
                tail_reg <= prev_wdata;
            end
        end
    end

    // Request context and result payload.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg     <= s_mode;
            node_reg     <= rd_addr;
            in_range_reg <= (32'(s_node_index) < NODE_COUNT);
        end
        if (state_reg == ST_EVAL) begin
            p_reg       <= prev_rdata;
            n_reg       <= next_rdata;
            applied_reg <= guard_ok;
        end
        if (state_reg == ST_LINK_A) begin
            cap_reg <= tail_reg;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_applied_reg    <= applied_reg;
            m_list_empty_reg <= (head_reg == '0);
            m_head_index_reg <= head_ext[lru_ill_pkg::NODE_W-1:0];
            m_tail_index_reg <= tail_ext[lru_ill_pkg::NODE_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_applied    = m_applied_reg;
    assign m_list_empty = m_list_empty_reg;
    assign m_head_index = m_head_index_reg;
    assign m_tail_index = m_tail_index_reg;

    // Hold off requests for the whole clearing pass.
    `LRU_ILL_ASSERT_IMPL(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_ready)
    // Between requests the list is empty from both ends or from neither.
    `LRU_ILL_ASSERT_IMPL(a_root_consistent, state_reg == ST_IDLE, (head_reg == '0) == (tail_reg == '0))
    // Guard evaluation always follows an accepted word.
    `LRU_ILL_ASSERT_NEXT(a_eval_after_accept, in_accept, state_reg == ST_EVAL)
    // Drop no link write outside the write steps and the clearing pass.
    `LRU_ILL_ASSERT_IMPL(a_write_in_steps, quiet_state, !prev_we && !next_we)

endmodule

`default_nettype wire
